// File: rtl/rsp_pkg.sv
// rsp_pkg: shared types and constants for the run-length sprite palette decoder
// used by rsp_ram users, rle_sprite_palette_decoder and its checker
`default_nettype none

package rsp_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_ADDR_W      = $clog2(PALETTE_ENTRIES);
    localparam int COLOUR_W        = 6;
    localparam int PAL_W           = 3 * COLOUR_W;
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

    typedef enum logic [1:0] {
        KIND_PALETTE = 2'd0,
        KIND_START   = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    // decoded result waiting for the palette read data
    typedef struct packed {
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
        logic [7:0] alpha;
        logic [7:0] run_length;
        logic       row_end;
        logic       sprite_done;
        logic       use_colour;
    } pix_t;

endpackage

`default_nettype wire

// File: rtl/rle_sprite_palette_decoder.sv
// rle_sprite_palette_decoder: top level of the run-length sprite decoder
// depends on rsp_pkg and rsp_ram
//
// Takes palette writes, sprite starts and coded bytes on the s_ channel, one item
// per cycle while s_ready is high; it drops while a full stage waits on m_ready.
// Decoder state (pending literals, position, rows left) updates at the accepting
// edge, so items may follow each other in consecutive cycles. A result passes
// the stage register and registered palette read, then the output register, to
// the m_ channel. Palette entries that were never written return undefined colour.
`default_nettype none

module rle_sprite_palette_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output      logic       s_ready,
    input  wire logic [1:0] s_kind,
    input  wire logic [7:0] s_byte_value,
    input  wire logic [7:0] s_palette_index,
    input  wire logic [5:0] s_red_in,
    input  wire logic [5:0] s_green_in,
    input  wire logic [5:0] s_blue_in,
    input  wire logic [7:0] s_x_origin,
    input  wire logic [7:0] s_y_origin,
    input  wire logic [7:0] s_row_count,
    output      logic       m_valid,
    input  wire logic       m_ready,
    output      logic [8:0] m_pixel_x,
    output      logic [8:0] m_pixel_y,
    output      logic [7:0] m_red_out,
    output      logic [7:0] m_green_out,
    output      logic [7:0] m_blue_out,
    output      logic [7:0] m_alpha_out,
    output      logic [7:0] m_run_length,
    output      logic       m_row_end,
    output      logic       m_sprite_done
);

    logic [6:0] literal_left_reg, literal_left_next;
    logic [8:0] cur_x_reg, cur_x_next;
    logic [8:0] cur_y_reg, cur_y_next;
    logic [7:0] row_origin_reg, row_origin_next;
    logic [7:0] rows_left_reg, rows_left_next;

    logic              stage_valid_reg, stage_valid_next;
    rsp_pkg::pix_t     stage_reg, stage_next;
    logic              res_valid;
    rsp_pkg::pix_t     res;

    logic [rsp_pkg::PAL_W-1:0] pal_rdata;
    logic                      pal_we;
    logic                      accept;
    logic                      stage_advance;
    rsp_pkg::kind_t            kind;

    logic [8:0] out_x_reg, out_y_reg;
    logic [7:0] out_r_reg, out_g_reg, out_b_reg, out_a_reg, out_run_reg;
    logic       out_end_reg, out_done_reg;
    logic       out_valid_reg;

    assign kind          = rsp_pkg::kind_t'(s_kind);
    assign stage_advance = !out_valid_reg || m_ready;
    assign s_ready       = !stage_valid_reg || stage_advance;
    assign accept        = s_valid && s_ready;

    assign pal_we = accept && (kind == rsp_pkg::KIND_PALETTE)
                    && ({1'b0, s_palette_index} < rsp_pkg::PAL_LIMIT);

    rsp_ram #(
        .WIDTH(rsp_pkg::PAL_W),
        .DEPTH(rsp_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (s_palette_index[rsp_pkg::PAL_ADDR_W-1:0]),
        .wdata ({s_red_in, s_green_in, s_blue_in}),
        .re    (accept),
        .raddr (s_byte_value[rsp_pkg::PAL_ADDR_W-1:0]),
        .rdata (pal_rdata)
    );

    // decode of one item against the current state
    always_comb begin
        literal_left_next = literal_left_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        row_origin_next   = row_origin_reg;
        rows_left_next    = rows_left_reg;
        res_valid         = 1'b0;
        res.pixel_x       = cur_x_reg;
        res.pixel_y       = cur_y_reg;
        res.alpha         = rsp_pkg::ALPHA_CLEAR;
        res.run_length    = 8'd0;
        res.row_end       = 1'b0;
        res.sprite_done   = 1'b0;
        res.use_colour    = 1'b0;
        unique case (kind)
            rsp_pkg::KIND_START: begin
                row_origin_next   = s_x_origin;
                cur_x_next        = {1'b0, s_x_origin};
                cur_y_next        = {1'b0, s_y_origin};
                rows_left_next    = s_row_count;
                literal_left_next = 7'd0;
            end
            rsp_pkg::KIND_DATA: begin
                if (rows_left_reg != 8'd0) begin
                    if (literal_left_reg != 7'd0) begin
                        res_valid         = 1'b1;
                        res.alpha         = rsp_pkg::ALPHA_OPAQUE;
                        res.run_length    = 8'd1;
                        res.use_colour    = {1'b0, s_byte_value} < rsp_pkg::PAL_LIMIT;
                        cur_x_next        = cur_x_reg + 9'd1;
                        literal_left_next = literal_left_reg - 7'd1;
                    end else if (s_byte_value == 8'd0) begin
                        res_valid       = 1'b1;
                        res.row_end     = 1'b1;
                        res.sprite_done = (rows_left_reg == 8'd1);
                        rows_left_next  = rows_left_reg - 8'd1;
                        cur_y_next      = cur_y_reg + 9'd1;
                        cur_x_next      = {1'b0, row_origin_reg};
                    end else if (!s_byte_value[7]) begin
                        literal_left_next = s_byte_value[6:0];
                    end else begin
                        res_valid      = 1'b1;
                        res.run_length = (~s_byte_value) + 8'd1;
                        cur_x_next     = cur_x_reg + {1'b0, res.run_length};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (accept) begin
            stage_valid_next = res_valid;
            stage_next       = res;
        end else if (stage_advance) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            literal_left_reg <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            row_origin_reg   <= '0;
            rows_left_reg    <= '0;
            stage_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                literal_left_reg <= literal_left_next;
                cur_x_reg        <= cur_x_next;
                cur_y_reg        <= cur_y_next;
                row_origin_reg   <= row_origin_next;
                rows_left_reg    <= rows_left_next;
            end
            stage_valid_reg <= stage_valid_next;
            if (stage_advance) begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
        if (stage_advance && stage_valid_reg) begin
            out_x_reg    <= stage_reg.pixel_x;
            out_y_reg    <= stage_reg.pixel_y;
            out_a_reg    <= stage_reg.alpha;
            out_run_reg  <= stage_reg.run_length;
            out_end_reg  <= stage_reg.row_end;
            out_done_reg <= stage_reg.sprite_done;
            if (stage_reg.use_colour) begin
                out_r_reg <= {pal_rdata[17:12], 2'b00};
                out_g_reg <= {pal_rdata[11:6], 2'b00};
                out_b_reg <= {pal_rdata[5:0], 2'b00};
            end else begin
                out_r_reg <= 8'd0;
                out_g_reg <= 8'd0;
                out_b_reg <= 8'd0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_x     = out_x_reg;
    assign m_pixel_y     = out_y_reg;
    assign m_red_out     = out_r_reg;
    assign m_green_out   = out_g_reg;
    assign m_blue_out    = out_b_reg;
    assign m_alpha_out   = out_a_reg;
    assign m_run_length  = out_run_reg;
    assign m_row_end     = out_end_reg;
    assign m_sprite_done = out_done_reg;

endmodule

`default_nettype wire

// File: rtl/rsp_ram.sv
// rsp_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rsp_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/rsp_checker.sv
// rsp_checker: port-level assertions for rle_sprite_palette_decoder
// depends on rsp_pkg; bound to the top level below
`default_nettype none

module rsp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [8:0] m_pixel_x,
    input wire logic [8:0] m_pixel_y,
    input wire logic [7:0] m_red_out,
    input wire logic [7:0] m_green_out,
    input wire logic [7:0] m_blue_out,
    input wire logic [7:0] m_alpha_out,
    input wire logic [7:0] m_run_length,
    input wire logic       m_row_end,
    input wire logic       m_sprite_done
);

    // stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
        && $stable(m_run_length) && $stable(m_red_out))
        else $error("stalled item changed");

    // last row only ends on a row end marker
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sprite_done |-> m_row_end)
        else $error("sprite done without row end");

    a_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_end |-> m_run_length == 8'd0
        && m_alpha_out == rsp_pkg::ALPHA_CLEAR)
        else $error("row end carries pixels");

    // opaque items are single pixels, transparent ones carry no colour
    a_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alpha_out == rsp_pkg::ALPHA_OPAQUE |-> m_run_length == 8'd1)
        else $error("literal run length not one");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alpha_out == rsp_pkg::ALPHA_CLEAR |-> m_red_out == 8'd0
        && m_green_out == 8'd0 && m_blue_out == 8'd0)
        else $error("transparent item has colour");

endmodule

bind rle_sprite_palette_decoder rsp_checker u_rsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_pixel_x     (m_pixel_x),
    .m_pixel_y     (m_pixel_y),
    .m_red_out     (m_red_out),
    .m_green_out   (m_green_out),
    .m_blue_out    (m_blue_out),
    .m_alpha_out   (m_alpha_out),
    .m_run_length  (m_run_length),
    .m_row_end     (m_row_end),
    .m_sprite_done (m_sprite_done)
);

`default_nettype wire
